// ===== rtl/core/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, status codes and the scan and command structs of the
// least-frequently-used key/value cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotW   = 4;

  localparam logic [StatusW-1:0] StMiss    = 3'd0;
  localparam logic [StatusW-1:0] StHit     = 3'd1;
  localparam logic [StatusW-1:0] StFilled  = 3'd2;
  localparam logic [StatusW-1:0] StPresent = 3'd3;
  localparam logic [StatusW-1:0] StEvicted = 3'd4;

  // running search result handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              hit;
    logic              empty;
    logic              minv;
    logic [CountW-1:0] min_cnt;
  } scan_t;

  // update broadcast to the cells once a search has finished
  typedef struct packed {
    logic en;
    logic wr;
    logic inc;
  } cmd_t;

endpackage

// ===== rtl/core/lfu_fully_associative_cache.sv =====
// ----------------------------------------------------------------------------
// lfu_fully_associative_cache
// Fully associative key/value cache with least-frequently-used replacement,
// built as a row of entry cells that a search result ripples through.
// ----------------------------------------------------------------------------
// an accepted item is registered, its search then walks the cell row one entry
//   per cycle, and the decision is registered on m_axis once the output is free
// a new item is taken only in Idle, after the last search's update is applied
// the result register lets a new item enter while the last result waits
// reset: all entries invalid with zero counts, no result pending
module lfu_fully_associative_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_out[31:0], slot[35:32], zero[39:36]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import lfu_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Done
  } state_e;

  state_e           state_q;
  logic             start_q;
  logic             act_q;
  logic [KeyW-1:0]  key_q;
  logic [ValW-1:0]  value_q;

  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [ValW-1:0]    data_q;
  logic [SlotW-1:0]   slot_q;

  scan_t           scan_w      [ENTRIES+1];
  logic [IW-1:0]   hit_idx_w   [ENTRIES+1];
  logic [IW-1:0]   empty_idx_w [ENTRIES+1];
  logic [IW-1:0]   min_idx_w   [ENTRIES+1];
  logic [ValW-1:0] hit_val_w   [ENTRIES+1];

  cmd_t                cmd;
  logic [IW-1:0]       cmd_idx;
  logic [StatusW-1:0]  status_d;
  logic [ValW-1:0]     data_d;
  logic [IW+SlotW-1:0] slot_wide;
  logic                fire;
  scan_t               res;

  assign s_axis_tready = (state_q == Idle);
  assign res           = scan_w[ENTRIES];
  assign fire          = (state_q == Done) && (!out_valid_q || m_axis_tready);

  assign scan_w[0]      = '{vld: start_q, hit: 1'b0, empty: 1'b0, minv: 1'b0, min_cnt: '0};
  assign hit_idx_w[0]   = '0;
  assign empty_idx_w[0] = '0;
  assign min_idx_w[0]   = '0;
  assign hit_val_w[0]   = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .IW (IW),
      .IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (key_q),
      .scan_i     (scan_w[g]),
      .hit_idx_i  (hit_idx_w[g]),
      .empty_idx_i(empty_idx_w[g]),
      .min_idx_i  (min_idx_w[g]),
      .hit_val_i  (hit_val_w[g]),
      .scan_o     (scan_w[g+1]),
      .hit_idx_o  (hit_idx_w[g+1]),
      .empty_idx_o(empty_idx_w[g+1]),
      .min_idx_o  (min_idx_w[g+1]),
      .hit_val_o  (hit_val_w[g+1]),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx),
      .wr_key_i   (key_q),
      .wr_value_i (value_q)
    );
  end

  // decision from the end of the row
  always_comb begin
    cmd      = '{en: fire, wr: 1'b0, inc: 1'b0};
    cmd_idx  = hit_idx_w[ENTRIES];
    status_d = StMiss;
    data_d   = '0;
    if (!act_q) begin
      if (res.hit) begin
        cmd.inc  = 1'b1;
        status_d = StHit;
        data_d   = hit_val_w[ENTRIES];
      end
    end else if (res.hit) begin
      status_d = StPresent;
    end else if (res.empty) begin
      cmd.wr   = 1'b1;
      cmd_idx  = empty_idx_w[ENTRIES];
      status_d = StFilled;
    end else begin
      cmd.wr   = 1'b1;
      cmd_idx  = min_idx_w[ENTRIES];
      status_d = StEvicted;
    end
    slot_wide = (IW+SlotW)'(cmd_idx);
    if (!act_q && !res.hit) begin
      slot_wide = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= (state_q == Idle) && s_axis_tvalid;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        Idle: begin
          if (s_axis_tvalid) begin
            state_q <= Scan;
          end
        end
        Scan: begin
          if (res.vld) begin
            state_q <= Done;
          end
        end
        Done: begin
          if (fire) begin
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act_q   <= s_axis_tuser[0];
      key_q   <= s_axis_tdata[31:0];
      value_q <= s_axis_tdata[63:32];
    end
    if (fire) begin
      status_q <= status_d;
      data_q   <= data_d;
      slot_q   <= slot_wide[SlotW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {4'b0000, slot_q, data_q};

endmodule

// ===== rtl/core/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry: valid flag, key, value and use count. Folds its entry into
// the search result coming from the previous cell and registers it for the
// next one; applies the fill or count update addressed to it.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [lfu_pkg::KeyW-1:0] key_i,
  input  lfu_pkg::scan_t         scan_i,
  input  logic [IW-1:0]          hit_idx_i,
  input  logic [IW-1:0]          empty_idx_i,
  input  logic [IW-1:0]          min_idx_i,
  input  logic [lfu_pkg::ValW-1:0] hit_val_i,
  output lfu_pkg::scan_t         scan_o,
  output logic [IW-1:0]          hit_idx_o,
  output logic [IW-1:0]          empty_idx_o,
  output logic [IW-1:0]          min_idx_o,
  output logic [lfu_pkg::ValW-1:0] hit_val_o,
  input  lfu_pkg::cmd_t          cmd_i,
  input  logic [IW-1:0]          cmd_idx_i,
  input  logic [lfu_pkg::KeyW-1:0] wr_key_i,
  input  logic [lfu_pkg::ValW-1:0] wr_value_i
);
  import lfu_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic              valid_q;
  logic [CountW-1:0] count_q;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   value_q;
  logic              sel;

  scan_t             scan_d, scan_q;
  logic [IW-1:0]     hit_idx_d, hit_idx_q;
  logic [IW-1:0]     empty_idx_d, empty_idx_q;
  logic [IW-1:0]     min_idx_d, min_idx_q;
  logic [ValW-1:0]   hit_val_d, hit_val_q;

  assign sel = cmd_i.en && (cmd_idx_i == MyIdx);

  always_comb begin
    scan_d      = scan_i;
    hit_idx_d   = hit_idx_i;
    empty_idx_d = empty_idx_i;
    min_idx_d   = min_idx_i;
    hit_val_d   = hit_val_i;
    // first valid match wins
    if (!scan_i.hit && valid_q && (key_q == key_i)) begin
      scan_d.hit = 1'b1;
      hit_idx_d  = MyIdx;
      hit_val_d  = value_q;
    end
    if (!scan_i.empty && !valid_q) begin
      scan_d.empty = 1'b1;
      empty_idx_d  = MyIdx;
    end
    // strict compare keeps the lowest index on ties
    if (!scan_i.minv || (count_q < scan_i.min_cnt)) begin
      scan_d.minv    = 1'b1;
      scan_d.min_cnt = count_q;
      min_idx_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      hit_idx_q   <= '0;
      empty_idx_q <= '0;
      min_idx_q   <= '0;
      hit_val_q   <= '0;
      valid_q     <= 1'b0;
      count_q     <= '0;
    end else begin
      if (scan_i.vld) begin
        scan_q      <= scan_d;
        hit_idx_q   <= hit_idx_d;
        empty_idx_q <= empty_idx_d;
        min_idx_q   <= min_idx_d;
        hit_val_q   <= hit_val_d;
      end else begin
        scan_q.vld <= 1'b0;
      end
      if (sel && cmd_i.wr) begin
        valid_q <= 1'b1;
        count_q <= CountW'(1);
      end else if (sel && cmd_i.inc && (count_q != '1)) begin
        count_q <= count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmd_i.wr) begin
      key_q   <= wr_key_i;
      value_q <= wr_value_i;
    end
  end

  assign scan_o      = scan_q;
  assign hit_idx_o   = hit_idx_q;
  assign empty_idx_o = empty_idx_q;
  assign min_idx_o   = min_idx_q;
  assign hit_val_o   = hit_val_q;

endmodule
